// ===== rtl/ipv4p_pkg.sv =====
package ipv4p_pkg;

    localparam int unsigned ChWidth   = 8;
    localparam int unsigned PartWidth = 8;
    localparam int unsigned NumParts  = 4;
    localparam int unsigned AddrWidth = PartWidth * NumParts;
    localparam int unsigned DotWidth  = 3;

    localparam logic [ChWidth-1:0] CH_NUL   = 8'h00;
    localparam logic [ChWidth-1:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [ChWidth-1:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [ChWidth-1:0] CH_DOT   = 8'h2E;   // '.'

    localparam logic [DotWidth-1:0] DOTS_ONE   = 3'd1;
    localparam logic [DotWidth-1:0] DOTS_TWO   = 3'd2;
    localparam logic [DotWidth-1:0] DOTS_THREE = 3'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef logic [PartWidth-1:0] t_part;

    typedef struct packed {
        logic                 status;
        logic [AddrWidth-1:0] address;
    } t_result;

endpackage

// ===== rtl/ipv4p_core.sv =====
module ipv4p_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [ipv4p_pkg::ChWidth-1:0] i_ch,
    output logic                         o_res_valid,
    output ipv4p_pkg::t_result           o_res
);
    import ipv4p_pkg::*;

    t_part                r_part [NumParts];
    t_part                n_part [NumParts];
    logic [DotWidth-1:0]  r_dots, n_dots;
    logic                 r_bad, n_bad;

    logic                 is_nul, is_dec, is_dot;
    logic [1:0]           idx;
    t_part                digit, cur, scaled;

    assign is_nul   = (i_ch == CH_NUL);
    assign is_dec   = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_dot   = (i_ch == CH_DOT);
    assign idx      = r_dots[1:0];
    assign digit    = i_ch - CH_ZERO;
    assign cur      = r_part[idx];
    // part * 10 + digit, wrapping at 256
    assign scaled   = (cur << 3) + (cur << 1) + digit;

    always_comb begin
        for (int i = 0; i < NumParts; i++) begin
            n_part[i] = r_part[i];
        end
        n_dots      = r_dots;
        n_bad       = r_bad;
        o_res_valid = 1'b0;
        o_res       = '{status: STATUS_BAD, address: '0};

        if (i_valid) begin
            if (is_nul) begin
                o_res_valid = 1'b1;
                if (!r_bad) begin
                    if (r_dots == DOTS_THREE) begin
                        o_res = '{status: STATUS_OK,
                                  address: {r_part[3], r_part[2], r_part[1], r_part[0]}};
                    end else if (r_dots == DOTS_TWO) begin
                        o_res = '{status: STATUS_OK,
                                  address: {r_part[2], {PartWidth{1'b0}},
                                            r_part[1], r_part[0]}};
                    end else if (r_dots == DOTS_ONE) begin
                        o_res = '{status: STATUS_OK,
                                  address: {r_part[1], {(2*PartWidth){1'b0}}, r_part[0]}};
                    end
                end
                // clear for the next string
                for (int i = 0; i < NumParts; i++) begin
                    n_part[i] = '0;
                end
                n_dots = '0;
                n_bad  = 1'b0;
            end else if (!r_bad) begin
                if (is_dec) begin
                    n_part[idx] = scaled;
                end else if (is_dot) begin
                    if (r_dots >= DOTS_THREE) begin
                        n_bad = 1'b1;
                    end else begin
                        n_dots = r_dots + DOTS_ONE;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumParts; i++) begin
                r_part[i] <= '0;
            end
            r_dots <= '0;
            r_bad  <= 1'b0;
        end else begin
            for (int i = 0; i < NumParts; i++) begin
                r_part[i] <= n_part[i];
            end
            r_dots <= n_dots;
            r_bad  <= n_bad;
        end
    end

endmodule

// ===== rtl/ipv4_dotted_text_parser_top.sv =====
// A zero byte passes the input register; its result is held in the result or skid word.
// Throughput: one byte per cycle; the slave side stalls only while a result waits in the
// skid word or a terminator in the input register is about to spill into it.
// The rate is set by the combinational part update (multiply by ten and add) in ipv4p_core.
// Reset (i_rst_n, synchronous, active low) clears the parts, dot count, error flag
// and all valid flags; the result and skid words hold their payload without reset.
module ipv4_dotted_text_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: text bytes
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ipv4p_pkg::ChWidth-1:0]      i_s_tdata,   // [7:0] ch
    // master side: parsed addresses
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ipv4p_pkg::AddrWidth-1:0]    o_m_tdata,   // [31:0] address
    output logic [0:0]                         o_m_tuser    // [0] status
);
    import ipv4p_pkg::*;

    // input register
    logic               r_in_valid;
    logic [ChWidth-1:0] r_in_ch;

    // result register and one-word skid behind it
    logic               r_out_valid;
    t_result            r_out;
    logic               r_sk_valid;
    t_result            r_sk;

    logic               res_valid;
    t_result            res;
    logic               out_free;
    logic               pending_to_skid;

    ipv4p_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_ch        (r_in_ch),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The result word is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || i_m_tready;

    // A terminator sitting in the input register that will spill into the skid.
    assign pending_to_skid = r_in_valid && (r_in_ch == CH_NUL) && !out_free;

    // Take a new byte only when the skid is empty and no terminator is about to spill
    // into it, so the skid has room for whatever the new byte produces.
    assign o_s_tready = !r_sk_valid && !pending_to_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_s_tvalid && o_s_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch <= i_s_tdata;
        end
    end

    // Output side: advance the skid into the result word when it frees up,
    // then park any fresh result in whichever word is left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= res_valid;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out <= r_sk;
                if (res_valid) begin
                    r_sk <= res;
                end
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_sk <= res;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out.address;
    assign o_m_tuser[0] = r_out.status;

endmodule
